// File: sv/sacl_pkg.sv
// Shared types, constants and helper functions for the set-associative cache simulator.
// No dependencies; the other files, apart from sacl_ram, refer to this package by scoped names.
package sacl_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_WIDTH   = 48;

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int STAMP_W  = 32;
	localparam int CNT_W    = 32;
	localparam int SHIFT_W  = 6;

	localparam int SET_BITS_W = 3;
	localparam int WAYS_W     = 4;
	localparam int BLOCK_W    = 5;
	localparam int FUNC_W     = 2;
	localparam int HITS_W     = 2;
	localparam int PDATA_W    = 32;
	localparam int PADDR_W    = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_STORE  = 2'd1,
		FUNC_MODIFY = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_SET_BITS   = 2'd0,
		REG_WAYS       = 2'd1,
		REG_BLOCK_BITS = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SET_BITS_W-1:0] set_bits;
		logic [WAYS_W-1:0]     ways_in_use;
		logic [BLOCK_W-1:0]    block_bits;
	} cfg_t;

	// One set of the tag store, kept as a single memory row.
	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
		logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic capture;
		logic rd;
		logic load;
		logic scan;
		logic update;
		logic write;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic no_access;
		logic out_free;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [HITS_W-1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W + 1)'(n);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic logic [SB_W-1:0] clamp_set_bits(input logic [SET_BITS_W-1:0] v);
		int unsigned n;
		n = v;
		if (n > MAX_SET_BITS)
			n = MAX_SET_BITS;
		return SB_W'(n);
	endfunction

	function automatic logic [WAY_W-1:0] last_way(input logic [WAYS_W-1:0] v);
		int unsigned n;
		n = v;
		if (n == 0)
			n = 1;
		if (n > MAX_WAYS)
			n = MAX_WAYS;
		return WAY_W'(n - 1);
	endfunction

endpackage

// File: sv/sacl_if.sv
// Valid/ready channel interfaces for access words in and result words out.
// Depends on sacl_pkg for field widths.
interface sacl_in_if;
	logic                             valid;
	logic                             ready;
	logic [sacl_pkg::FUNC_W-1:0]      func;
	logic [sacl_pkg::ADDR_WIDTH-1:0]  address;

	modport source(output valid, func, address, input ready);
	modport sink(input valid, func, address, output ready);
endinterface

interface sacl_out_if;
	logic                         valid;
	logic                         ready;
	logic [sacl_pkg::HITS_W-1:0]  hits_added;
	logic                         missed;
	logic                         evicted;
	logic [sacl_pkg::CNT_W-1:0]   total_hits;
	logic [sacl_pkg::CNT_W-1:0]   total_misses;
	logic [sacl_pkg::CNT_W-1:0]   total_evictions;

	modport source(output valid, hits_added, missed, evicted, total_hits, total_misses,
		total_evictions, input ready);
	modport sink(input valid, hits_added, missed, evicted, total_hits, total_misses,
		total_evictions, output ready);
endinterface

// File: sv/set_assoc_cache_lru_sim_top.sv
// Top level of the set-associative cache tag-store simulator with LRU replacement.
// Depends on sacl_pkg, sacl_if, sacl_cfg, sacl_ctrl, sacl_dp and sacl_ram.

// Each access word (func, address) looks up one set of a tag store with up to 8 ways and
// 64 sets and returns one result word: hits this word caused (0..2, a modify counts two
// accesses), whether the first access missed, whether a valid line was evicted, and the
// running saturating totals of hits, misses and evictions. The whole set lives in one row
// of a single memory (valid bits, tags and 32-bit recency stamps of all ways). A word is
// accepted, its set row read and loaded, then the ways in use (ways_in_use, with 0 taken
// as 1 and anything above 8 as 8) are scanned one per cycle through a single compare unit,
// the set is updated and then written back while the result is loaded. The next word can
// be taken in the cycle the result word first shows valid. A func code of 3 skips the scan.
// The output register lets the block take the next word while a result still waits; a new
// result waits for that register to drain. No clearing pass is needed after reset: a
// per-set flag marks rows never written, which read as empty. Configuration (set_bits at
// 0x0, ways_in_use at 0x4, block_bits at 0x8) may only be written while the block is idle,
// and changing it does not flush the store.
module set_assoc_cache_lru_sim_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
	input  logic [sacl_pkg::PDATA_W-1:0]   pwdata,
	output logic [sacl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	sacl_in_if.sink                        req,
	sacl_out_if.source                     rsp
);

	sacl_pkg::cfg_t       cfg;
	sacl_pkg::ctrl_cmd_t  cmd;
	sacl_pkg::dp_stat_t   stat;
	logic                 req_ready;

	// Register file on the APB side.
	sacl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: owns the input handshake and steps the datapath.
	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = req_ready;

	// Datapath: holds the set row, scan state, totals and the result register.
	sacl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.req_func    (req.func),
		.req_address (req.address),
		.rsp         (rsp)
	);

endmodule

// File: sv/sacl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/sacl_cfg.sv
// APB-style configuration registers: set bits, ways in use, block bits.
// Depends on sacl_pkg.
module sacl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sacl_pkg::PADDR_W-1:0]   paddr,
	input  logic [sacl_pkg::PDATA_W-1:0]   pwdata,
	output logic [sacl_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output sacl_pkg::cfg_t                 cfg
);

	sacl_pkg::cfg_t     cfg_q;
	sacl_pkg::reg_idx_t idx;
	logic               wr;

	assign idx    = sacl_pkg::reg_idx_t'(paddr[sacl_pkg::PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_bits    <= sacl_pkg::SET_BITS_W'(1);
			cfg_q.ways_in_use <= sacl_pkg::WAYS_W'(8);
			cfg_q.block_bits  <= sacl_pkg::BLOCK_W'(4);
		end else if (wr) begin
			case (idx)
				sacl_pkg::REG_SET_BITS:   cfg_q.set_bits    <= pwdata[sacl_pkg::SET_BITS_W-1:0];
				sacl_pkg::REG_WAYS:       cfg_q.ways_in_use <= pwdata[sacl_pkg::WAYS_W-1:0];
				sacl_pkg::REG_BLOCK_BITS: cfg_q.block_bits  <= pwdata[sacl_pkg::BLOCK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sacl_pkg::REG_SET_BITS:   prdata = sacl_pkg::PDATA_W'(cfg_q.set_bits);
			sacl_pkg::REG_WAYS:       prdata = sacl_pkg::PDATA_W'(cfg_q.ways_in_use);
			sacl_pkg::REG_BLOCK_BITS: prdata = sacl_pkg::PDATA_W'(cfg_q.block_bits);
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/sacl_ctrl.sv
// Sequencing state machine: accept, row read, way scan, update, write-back and result.
// Depends on sacl_pkg.
module sacl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  sacl_pkg::dp_stat_t    stat,
	output sacl_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_READ   = 6'b000010,
		S_LOAD   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_UPDATE = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = stat.no_access ? S_UPDATE : S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				// rewriting the same row while the result slot is busy is harmless
				cmd.write = 1'b1;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_READ)
		else $error("accepted word did not start a row read");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && stat.scan_last |=> state_q == S_UPDATE)
		else $error("scan of last way did not lead to update");

endmodule

// File: sv/sacl_dp.sv
// Datapath: address split, set row buffer, way scan registers, totals and result register.
// Depends on sacl_pkg, sacl_if and sacl_ram.
module sacl_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sacl_pkg::cfg_t                   cfg,
	input  sacl_pkg::ctrl_cmd_t              cmd,
	output sacl_pkg::dp_stat_t               stat,
	input  logic [sacl_pkg::FUNC_W-1:0]      req_func,
	input  logic [sacl_pkg::ADDR_WIDTH-1:0]  req_address,
	sacl_out_if.source                       rsp
);

	sacl_pkg::func_t                    func_q;
	logic [sacl_pkg::ADDR_WIDTH-1:0]    addr_q;

	logic [sacl_pkg::SB_W-1:0]          sb;
	logic [sacl_pkg::ADDR_WIDTH-1:0]    shifted;
	logic [sacl_pkg::SET_W:0]           set_mask;
	logic [sacl_pkg::SET_W-1:0]         sidx;
	logic [sacl_pkg::SHIFT_W-1:0]       tag_sh;
	logic [sacl_pkg::ADDR_WIDTH-1:0]    tag;

	logic [sacl_pkg::NUM_SETS-1:0]      row_valid_q;
	logic [sacl_pkg::ROW_W-1:0]         ram_rdata;
	logic                               ram_we;
	sacl_pkg::row_t                     row_q, row_n;

	logic [sacl_pkg::WAY_W-1:0]         way_q;
	logic [sacl_pkg::STAMP_W-1:0]       newest_q;
	logic                               hit_found_q, empty_found_q;
	logic [sacl_pkg::WAY_W-1:0]         hit_way_q, empty_way_q, victim_q;
	logic [sacl_pkg::STAMP_W-1:0]       victim_stamp_q;

	logic [sacl_pkg::STAMP_W-1:0]       sw;
	logic                               vw;
	logic                               modify;
	logic [sacl_pkg::STAMP_W-1:0]       stamp1, stamp2;
	logic [sacl_pkg::WAY_W-1:0]         acc_way;
	logic [sacl_pkg::HITS_W-1:0]        hits_n;
	logic                               missed_n, evicted_n;

	logic [sacl_pkg::CNT_W-1:0]         hits_q, misses_q, evicts_q;
	logic [sacl_pkg::HITS_W-1:0]        res_hits_q;
	logic                               res_missed_q, res_evicted_q;

	logic                               out_valid_q;
	logic [sacl_pkg::HITS_W-1:0]        out_hits_q;
	logic                               out_missed_q, out_evicted_q;
	logic [sacl_pkg::CNT_W-1:0]         out_th_q, out_tm_q, out_te_q;

	// Split the address: offset below, set index in the middle, tag above.
	assign sb       = sacl_pkg::clamp_set_bits(cfg.set_bits);
	assign shifted  = addr_q >> cfg.block_bits;
	assign set_mask = ((sacl_pkg::SET_W + 1)'(1) << sb) - (sacl_pkg::SET_W + 1)'(1);
	assign sidx     = shifted[sacl_pkg::SET_W-1:0] & set_mask[sacl_pkg::SET_W-1:0];
	assign tag_sh   = sacl_pkg::SHIFT_W'(cfg.block_bits) + sacl_pkg::SHIFT_W'(sb);
	assign tag      = addr_q >> tag_sh;

	assign stat.no_access = (func_q == sacl_pkg::FUNC_NONE);
	assign stat.scan_last = (way_q == sacl_pkg::last_way(cfg.ways_in_use));
	assign stat.out_free  = !out_valid_q || rsp.ready;

	assign ram_we = cmd.write && !stat.no_access;

	sacl_ram #(
		.WIDTH(sacl_pkg::ROW_W),
		.DEPTH(sacl_pkg::NUM_SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sidx),
		.wdata (row_q),
		.re    (cmd.rd),
		.raddr (sidx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= sacl_pkg::func_t'(req_func);
			addr_q <= req_address;
		end
	end

	// A set never written reads as all ways invalid with zero stamps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (ram_we)
			row_valid_q[sidx] <= 1'b1;
	end

	assign sw = row_q.stamp[way_q];
	assign vw = row_q.valid[way_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q       <= row_valid_q[sidx] ? sacl_pkg::row_t'(ram_rdata) : '0;
			way_q       <= '0;
			newest_q    <= '0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmd.scan) begin
			way_q <= way_q + sacl_pkg::WAY_W'(1);
			if (sw > newest_q)
				newest_q <= sw;
			if (vw && row_q.tag[way_q] == tag && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_way_q   <= way_q;
			end
			if (!vw && !empty_found_q) begin
				empty_found_q <= 1'b1;
				empty_way_q   <= way_q;
			end
			// strict compare keeps the lowest way on ties
			if (way_q == '0 || sw < victim_stamp_q) begin
				victim_q       <= way_q;
				victim_stamp_q <= sw;
			end
		end else if (cmd.update && !stat.no_access) begin
			row_q <= row_n;
		end
	end

	// The second access of a modify always hits the way just touched, which now
	// holds the newest stamp, so bump that stamp once more.
	assign modify  = (func_q == sacl_pkg::FUNC_MODIFY);
	assign stamp1  = sacl_pkg::sat_inc(newest_q);
	assign stamp2  = sacl_pkg::sat_inc(stamp1);
	assign acc_way = hit_found_q ? hit_way_q : (empty_found_q ? empty_way_q : victim_q);

	always_comb begin
		row_n                = row_q;
		row_n.valid[acc_way] = 1'b1;
		row_n.tag[acc_way]   = tag;
		row_n.stamp[acc_way] = modify ? stamp2 : stamp1;
	end

	always_comb begin
		if (stat.no_access) begin
			hits_n    = '0;
			missed_n  = 1'b0;
			evicted_n = 1'b0;
		end else begin
			hits_n    = {1'b0, hit_found_q} + {1'b0, modify};
			missed_n  = !hit_found_q;
			evicted_n = !hit_found_q && !empty_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
		end else if (cmd.update) begin
			hits_q <= sacl_pkg::sat_add(hits_q, hits_n);
			if (missed_n)
				misses_q <= sacl_pkg::sat_inc(misses_q);
			if (evicted_n)
				evicts_q <= sacl_pkg::sat_inc(evicts_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_hits_q    <= hits_n;
			res_missed_q  <= missed_n;
			res_evicted_q <= evicted_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_hits_q    <= res_hits_q;
			out_missed_q  <= res_missed_q;
			out_evicted_q <= res_evicted_q;
			out_th_q      <= hits_q;
			out_tm_q      <= misses_q;
			out_te_q      <= evicts_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hits_added      = out_hits_q;
	assign rsp.missed          = out_missed_q;
	assign rsp.evicted         = out_evicted_q;
	assign rsp.total_hits      = out_th_q;
	assign rsp.total_misses    = out_tm_q;
	assign rsp.total_evictions = out_te_q;

	a_evict_needs_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> rsp.missed)
		else $error("eviction reported without a miss");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> hits_q >= $past(hits_q) && misses_q >= $past(misses_q))
		else $error("running total went down");

endmodule
